>>> hdl/dmc_pkg.sv
// ---------------------------------------------------------------------------
// dmc_pkg
// shared constants for the direct-mapped cache core: register indexes,
// reset values, status codes and default sizes
// ---------------------------------------------------------------------------
package dmc_pkg;

    // default sizes
    localparam int ADDR_BITS_DEF = 10;
    localparam int DATA_BITS_DEF = 32;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd2;

    localparam logic [CFG_W-1:0] MEM_LOG2_RST   = 4'd10;
    localparam logic [CFG_W-1:0] CACHE_LOG2_RST = 4'd6;
    localparam logic [CFG_W-1:0] BLOCK_LOG2_RST = 4'd2;

    // result status
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXCEED = 2'd3;

endpackage

>>> hdl/dmc_ram.sv
// ---------------------------------------------------------------------------
// dmc_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module dmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dmc_init.sv
// ---------------------------------------------------------------------------
// dmc_init
// initialization sweep counter, walks every ram entry once after reset
// and after each restart request
// ---------------------------------------------------------------------------
module dmc_init #(
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    output logic                 o_active,
    output logic [ADDR_BITS-1:0] o_index
);

    logic                 r_active;
    logic                 n_active;
    logic [ADDR_BITS-1:0] r_index;
    logic [ADDR_BITS-1:0] n_index;

    always_comb begin
        n_active = r_active;
        n_index  = r_index;
        if (i_restart) begin
            n_active = 1'b1;
            n_index  = '0;
        end else if (r_active) begin
            if (r_index == {ADDR_BITS{1'b1}}) begin
                n_active = 1'b0;
            end
            n_index = r_index + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_index  <= '0;
        end else begin
            r_active <= n_active;
            r_index  <= n_index;
        end
    end

    assign o_active = r_active;
    assign o_index  = r_index;

endmodule

>>> hdl/direct_mapped_cache_sim_core.sv
// ---------------------------------------------------------------------------
// direct_mapped_cache_sim_core
// direct-mapped write-through, write-allocate cache in front of an internal
// word-addressed backing memory, reporting hit/miss and the memory word
// ---------------------------------------------------------------------------
// Usage: an item (func, address, write_value) is taken at a rising edge with
// start high and busy low. The core accepts one item per clock while busy is
// low and answers each with exactly one result, through the lookup stage and the
// result register: o_done is high for one cycle with status, offset, line, tag
// and data word on the o_ ports; the receiver cannot hold results off. Taking
// one item per clock rests on the single read port of each ram (tag/valid ram and
// backing ram) together with forwarding of the previous item's write-back. After
// reset, and after every write to a known configuration register, busy stays
// high while an initialization sweep clears all line valid bits and loads
// backing word i with (memory size - i). The user must write configuration only
// when no item is in flight; the core itself does not enforce it.
// ---------------------------------------------------------------------------
module direct_mapped_cache_sim_core #(
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = dmc_pkg::DATA_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_func,
    input  logic [ADDR_BITS-1:0]           i_address,
    input  logic signed [DATA_BITS-1:0]    i_write_value,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmc_pkg::CFG_W-1:0]      i_cfg_data,
    // result channel
    output logic                           o_done,
    output logic [dmc_pkg::STATUS_W-1:0]   o_status,
    output logic [ADDR_BITS-1:0]           o_word_offset,
    output logic [ADDR_BITS-1:0]           o_line_index,
    output logic [ADDR_BITS-1:0]           o_tag_value,
    output logic signed [DATA_BITS-1:0]    o_data_word
);

    import dmc_pkg::*;

    localparam int DEPTH  = 1 << ADDR_BITS;
    localparam int LOG_W  = $clog2(ADDR_BITS + 1);
    localparam int TAG_W  = ADDR_BITS + 1;              // valid bit on top of tag
    localparam int WIDE_W = DATA_BITS + ADDR_BITS + 2;  // init word arithmetic

    // clamp a log2 register to the address width
    function automatic logic [LOG_W-1:0] eff_log2(input logic [CFG_W-1:0] v);
        logic [LOG_W-1:0] res;
        if (int'(v) > ADDR_BITS) begin
            res = LOG_W'(ADDR_BITS);
        end else begin
            res = LOG_W'(v);
        end
        return res;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] r_mem_log2;
    logic [CFG_W-1:0] r_cache_log2;
    logic [CFG_W-1:0] r_block_log2;
    logic             cfg_known;

    // effective sizes
    logic [LOG_W-1:0] eff_m;
    logic [LOG_W-1:0] eff_c;
    logic [LOG_W-1:0] eff_b;

    // init sweep
    logic                 init_active;
    logic [ADDR_BITS-1:0] init_index;
    logic [WIDE_W-1:0]    init_diff;
    logic [DATA_BITS-1:0] init_word;

    // address split of the incoming item
    logic                 accept;
    logic [ADDR_BITS-1:0] s1_bmask;
    logic [ADDR_BITS-1:0] s1_cmask;
    logic [ADDR_BITS-1:0] s1_offset;
    logic [ADDR_BITS-1:0] s1_line;
    logic [ADDR_BITS-1:0] s1_tag;
    logic [STATUS_W-1:0]  s1_pre;

    // lookup stage registers
    logic                 r_s2_valid;
    logic                 r_s2_func;
    logic [ADDR_BITS-1:0] r_s2_addr;
    logic [DATA_BITS-1:0] r_s2_wval;
    logic [ADDR_BITS-1:0] r_s2_offset;
    logic [ADDR_BITS-1:0] r_s2_line;
    logic [ADDR_BITS-1:0] r_s2_tag;
    logic [STATUS_W-1:0]  r_s2_pre;

    // ram ports
    logic [TAG_W-1:0]     tag_rdata;
    logic [DATA_BITS-1:0] data_rdata;
    logic                 tag_we;
    logic [ADDR_BITS-1:0] tag_waddr;
    logic [TAG_W-1:0]     tag_wdata;
    logic                 data_we;
    logic [ADDR_BITS-1:0] data_waddr;
    logic [DATA_BITS-1:0] data_wdata;

    // lookup stage logic
    logic [TAG_W-1:0]     s2_entry;
    logic                 s2_ok;
    logic                 s2_hit;
    logic                 s2_tag_upd;
    logic                 s2_data_upd;
    logic [DATA_BITS-1:0] s2_old_word;
    logic [DATA_BITS-1:0] s2_word;

    // forwarding of the write-back done at the last edge
    logic                 r_fwd_tag_v;
    logic [ADDR_BITS-1:0] r_fwd_tag_line;
    logic [ADDR_BITS-1:0] r_fwd_tag;
    logic                 r_fwd_data_v;
    logic [ADDR_BITS-1:0] r_fwd_data_addr;
    logic [DATA_BITS-1:0] r_fwd_data;

    // result registers
    logic                 r_done;
    logic [STATUS_W-1:0]  r_status;
    logic [ADDR_BITS-1:0] r_offset;
    logic [ADDR_BITS-1:0] r_line;
    logic [ADDR_BITS-1:0] r_tag;
    logic [DATA_BITS-1:0] r_word;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg_known = i_cfg_we && (i_cfg_idx == CFG_MEM_LOG2 ||
                                    i_cfg_idx == CFG_CACHE_LOG2 ||
                                    i_cfg_idx == CFG_BLOCK_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_log2   <= MEM_LOG2_RST;
            r_cache_log2 <= CACHE_LOG2_RST;
            r_block_log2 <= BLOCK_LOG2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEM_LOG2:   r_mem_log2   <= i_cfg_data;
                CFG_CACHE_LOG2: r_cache_log2 <= i_cfg_data;
                CFG_BLOCK_LOG2: r_block_log2 <= i_cfg_data;
                default: ;  // unknown index, ignored
            endcase
        end
    end

    assign eff_m = eff_log2(r_mem_log2);
    assign eff_c = eff_log2(r_cache_log2);
    assign eff_b = eff_log2(r_block_log2);

    // ------------------------------------------------------------------
    // init sweep: clears valid bits, loads backing word i with size - i
    // ------------------------------------------------------------------
    dmc_init #(
        .ADDR_BITS (ADDR_BITS)
    ) u_init (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_known),
        .o_active  (init_active),
        .o_index   (init_index)
    );

    assign init_diff = (WIDE_W'(1) << eff_m) - WIDE_W'(init_index);
    assign init_word = init_diff[DATA_BITS-1:0];

    assign busy   = init_active;
    assign accept = start && !init_active;

    // ------------------------------------------------------------------
    // address split, done on the request ports so the rams read at accept
    // ------------------------------------------------------------------
    assign s1_bmask  = ~({ADDR_BITS{1'b1}} << eff_b);
    assign s1_cmask  = ~({ADDR_BITS{1'b1}} << eff_c);
    assign s1_offset = i_address & s1_bmask;
    assign s1_line   = (i_address & s1_cmask) >> eff_b;
    assign s1_tag    = i_address >> eff_c;

    always_comb begin
        if (eff_b > eff_c) begin
            s1_pre = ST_EXCEED;          // checked before the range
        end else if ((i_address >> eff_m) != '0) begin
            s1_pre = ST_RANGE;
        end else begin
            s1_pre = ST_HIT;             // in range, lookup decides
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_func   <= i_func;
            r_s2_addr   <= i_address;
            r_s2_wval   <= i_write_value;
            r_s2_offset <= s1_offset;
            r_s2_line   <= s1_line;
            r_s2_tag    <= s1_tag;
            r_s2_pre    <= s1_pre;
        end
    end

    // ------------------------------------------------------------------
    // memories: tag ram holds {valid, tag} per line, data ram the words
    // ------------------------------------------------------------------
    dmc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (accept),
        .i_raddr (s1_line),
        .o_rdata (tag_rdata)
    );

    dmc_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (accept),
        .i_raddr (i_address),
        .o_rdata (data_rdata)
    );

    // ------------------------------------------------------------------
    // lookup and write-back
    // ------------------------------------------------------------------
    // a line written back at the last edge may not be in the ram read data yet
    assign s2_entry = (r_fwd_tag_v && r_fwd_tag_line == r_s2_line) ?
                      {1'b1, r_fwd_tag} : tag_rdata;

    assign s2_ok       = r_s2_valid && (r_s2_pre == ST_HIT);
    assign s2_hit      = s2_entry[TAG_W-1] && (s2_entry[ADDR_BITS-1:0] == r_s2_tag);
    assign s2_tag_upd  = s2_ok && !s2_hit;    // allocate on any miss
    assign s2_data_upd = s2_ok && r_s2_func;  // write-through

    assign s2_old_word = (r_fwd_data_v && r_fwd_data_addr == r_s2_addr) ?
                         r_fwd_data : data_rdata;
    assign s2_word     = r_s2_func ? r_s2_wval : s2_old_word;

    // sweep owns the write ports while it runs; the user keeps items out of flight then, the core does not enforce it
    always_comb begin
        if (init_active) begin
            tag_we     = 1'b1;
            tag_waddr  = init_index;
            tag_wdata  = '0;
            data_we    = 1'b1;
            data_waddr = init_index;
            data_wdata = init_word;
        end else begin
            tag_we     = s2_tag_upd;
            tag_waddr  = r_s2_line;
            tag_wdata  = {1'b1, r_s2_tag};
            data_we    = s2_data_upd;
            data_waddr = r_s2_addr;
            data_wdata = r_s2_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_tag_v  <= 1'b0;
            r_fwd_data_v <= 1'b0;
        end else begin
            r_fwd_tag_v  <= s2_tag_upd && !init_active;
            r_fwd_data_v <= s2_data_upd && !init_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_tag_line  <= r_s2_line;
        r_fwd_tag       <= r_s2_tag;
        r_fwd_data_addr <= r_s2_addr;
        r_fwd_data      <= r_s2_wval;
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ok) begin
            r_status <= s2_hit ? ST_HIT : ST_MISS;
            r_offset <= r_s2_offset;
            r_line   <= r_s2_line;
            r_tag    <= r_s2_tag;
            r_word   <= s2_word;
        end else begin
            // flagged items report zeros beside the status
            r_status <= r_s2_pre;
            r_offset <= '0;
            r_line   <= '0;
            r_tag    <= '0;
            r_word   <= '0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_word_offset = r_offset;
    assign o_line_index  = r_line;
    assign o_tag_value   = r_tag;
    assign o_data_word   = r_word;

endmodule

>>> hdl/dmc_checker.sv
// ---------------------------------------------------------------------------
// dmc_checker
// port-level checks on the cache core, bound to the core module
// ---------------------------------------------------------------------------
module dmc_checker #(
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = dmc_pkg::DATA_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           i_cfg_we,
    input logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic                           o_done,
    input logic [dmc_pkg::STATUS_W-1:0]   o_status,
    input logic [ADDR_BITS-1:0]           o_word_offset,
    input logic [ADDR_BITS-1:0]           o_line_index,
    input logic [ADDR_BITS-1:0]           o_tag_value,
    input logic signed [DATA_BITS-1:0]    o_data_word
);

    import dmc_pkg::*;

    // reset starts the init sweep
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // a known register write restarts the sweep
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == CFG_MEM_LOG2 || i_cfg_idx == CFG_CACHE_LOG2 ||
                     i_cfg_idx == CFG_BLOCK_LOG2) |=> busy)
        else $error("configuration write did not start the sweep");

    // every accepted item is answered by a result strobe
    a_item_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_done)
        else $error("accepted item got no result");

    // no result without an earlier accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_rst_n, 2))
        else $error("result without an accepted item");

    // flagged items carry zero fields
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_RANGE || o_status == ST_EXCEED) |->
        o_word_offset == '0 && o_line_index == '0 && o_tag_value == '0 &&
        o_data_word == '0)
        else $error("flagged item carries nonzero fields");

endmodule

bind direct_mapped_cache_sim_core dmc_checker #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
) u_dmc_checker (.*);

>>> tb/sv/tb_direct_mapped_cache_sim_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_direct_mapped_cache_sim_core
// self-checking bench for the direct-mapped write-through cache core: a
// directed table of accesses and register writes, then random accesses over
// ten cache geometries, checked against listed results or a behavioral cache predictor
// ---------------------------------------------------------------------------
module tb_direct_mapped_cache_sim_core;

    import dmc_pkg::*;

    localparam int AW    = ADDR_BITS_DEF;
    localparam int DW    = DATA_BITS_DEF;
    localparam int DEPTH = 1 << AW;

    // access codes
    localparam bit FN_READ  = 1'b0;
    localparam bit FN_WRITE = 1'b1;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int MAX_SHOWN   = 10;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 183;
    localparam int DRAIN_LIMIT = 200;

    // memory, cache and block log2 per random phase, extremes and oversized included
    localparam int unsigned PHASE_SET [NUM_PHASES][3] = '{
        '{10, 6, 2}, '{10, 3, 1}, '{4, 2, 0}, '{15, 12, 4}, '{7, 5, 5},
        '{0, 0, 0}, '{10, 10, 10}, '{8, 4, 6}, '{10, 8, 3}, '{10, 1, 0}
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AW-1:0]       offset;
        logic [AW-1:0]       line;
        logic [AW-1:0]       tag;
        logic [DW-1:0]       data;
    } t_access_res;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        bit                   func;
        logic [AW-1:0]        addr;
        logic [DW-1:0]        wval;
        bit                   typed;
        t_access_res          want;
    } t_dir_row;

    // dut connections
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_func;
    logic [AW-1:0]           i_address;
    logic signed [DW-1:0]    i_write_value;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    o_done;
    logic [STATUS_W-1:0]     o_status;
    logic [AW-1:0]           o_word_offset;
    logic [AW-1:0]           o_line_index;
    logic [AW-1:0]           o_tag_value;
    logic signed [DW-1:0]    o_data_word;

    // predictor state: registers, tag store, valid bits, backing memory
    logic [CFG_W-1:0] cur_mem_log2;
    logic [CFG_W-1:0] cur_cache_log2;
    logic [CFG_W-1:0] cur_block_log2;
    logic [AW-1:0]    line_tag_copy [DEPTH];
    bit               line_valid_copy [DEPTH];
    logic [DW-1:0]    backing_copy [DEPTH];

    t_access_res pending_results [$];
    t_dir_row    directed_rows [$];

    int gap_pct;
    int items_sent;
    int results_seen;
    int cfg_writes;
    int mismatches;
    int status_count [4];

    direct_mapped_cache_sim_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_write_value (i_write_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_word_offset (o_word_offset),
        .o_line_index  (o_line_index),
        .o_tag_value   (o_tag_value),
        .o_data_word   (o_data_word)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // register values above the address width act as the address width
    function automatic int unsigned clip_log2(logic [CFG_W-1:0] v);
        return (v > AW) ? AW : v;
    endfunction

    // state after reset or any known register write: lines invalid, word i = size - i
    function automatic void reload_cache_state();
        int unsigned sz;
        sz = 1 << clip_log2(cur_mem_log2);
        for (int i = 0; i < DEPTH; i++) begin
            line_valid_copy[i] = 1'b0;
            line_tag_copy[i]   = '0;
            backing_copy[i]    = DW'(sz - i);
        end
    endfunction

    // one access through the cache; updates tags, valid bits and memory
    function automatic t_access_res predict_access(bit func, logic [AW-1:0] addr,
                                                   logic [DW-1:0] wval);
        t_access_res r;
        int unsigned m, c, b, a, ln;
        r = '0;
        m = clip_log2(cur_mem_log2);
        c = clip_log2(cur_cache_log2);
        b = clip_log2(cur_block_log2);
        a = addr;
        // oversized block wins over the address check, nothing changes
        if (b > c) begin
            r.status = ST_EXCEED;
            return r;
        end
        if (a >= (1 << m)) begin
            r.status = ST_RANGE;
            return r;
        end
        ln       = (a >> b) & ((1 << (c - b)) - 1);
        r.offset = AW'(a & ((1 << b) - 1));
        r.line   = AW'(ln);
        r.tag    = AW'(a >> c);
        if (line_valid_copy[ln] && line_tag_copy[ln] == r.tag) begin
            r.status = ST_HIT;
        end else begin
            // allocate on any miss, read or write
            r.status           = ST_MISS;
            line_tag_copy[ln]  = r.tag;
            line_valid_copy[ln] = 1'b1;
        end
        // write-through: memory always takes the value
        if (func == FN_WRITE) begin
            backing_copy[a] = wval;
        end
        r.data = backing_copy[a];
        return r;
    endfunction

    task automatic report_mismatch(string what, t_access_res want, t_access_res got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t %s: exp st %0d off %0d line %0d tag %0d data %h", $time, what,
                     want.status, want.offset, want.line, want.tag, want.data);
            $display("%0t %s: got st %0d off %0d line %0d tag %0d data %h", $time, what,
                     got.status, got.offset, got.line, got.tag, got.data);
        end
    endtask

    // result checker: every strobe is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_access_res got;
        t_access_res want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            got = {o_status, o_word_offset, o_line_index, o_tag_value, o_data_word};
            results_seen++;
            status_count[o_status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // present one item at a falling edge, hold it until taken, then predict
    task automatic send_access(bit func, logic [AW-1:0] addr, logic [DW-1:0] wval,
                               bit typed, t_access_res want);
        t_access_res pred;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_address     <= addr;
        i_write_value <= wval;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = predict_access(func, addr, wval);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    // register write while idle; a known register starts the init sweep
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // nothing may still be inside the pipeline
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
        cfg_writes++;
        case (idx)
            CFG_MEM_LOG2: begin
                cur_mem_log2 = val;
                reload_cache_state();
            end
            CFG_CACHE_LOG2: begin
                cur_cache_log2 = val;
                reload_cache_state();
            end
            CFG_BLOCK_LOG2: begin
                cur_block_log2 = val;
                reload_cache_state();
            end
            default: ;
        endcase
    endtask

    // directed table builders
    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_dir_row r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.func   = FN_READ;
        r.addr   = '0;
        r.wval   = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_access(bit func, logic [AW-1:0] addr, logic [DW-1:0] wval);
        t_dir_row r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.func   = func;
        r.addr   = addr;
        r.wval   = wval;
        r.typed  = 1'b0;
        r.want   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_known(bit func, logic [AW-1:0] addr, logic [DW-1:0] wval,
                                      logic [STATUS_W-1:0] st, int unsigned off,
                                      int unsigned ln, int unsigned tg, logic [DW-1:0] dw);
        row_access(func, addr, wval);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want  = {st, AW'(off), AW'(ln), AW'(tg), dw};
    endfunction

    initial begin
        logic [AW-1:0] recent [$];
        logic [AW-1:0] addr;
        logic [DW-1:0] wval;
        int unsigned   msize;
        int unsigned   csize;
        int unsigned   bsize;
        int unsigned   pick;
        int            drain_wait;
        int            leftover;

        // every input known from time zero, reset held low
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_func        = FN_READ;
        i_address     = '0;
        i_write_value = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MEM_LOG2;
        i_cfg_data    = '0;
        gap_pct       = 11;
        items_sent    = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        mismatches    = 0;
        for (int i = 0; i < 4; i++) status_count[i] = 0;

        cur_mem_log2   = MEM_LOG2_RST;
        cur_cache_log2 = CACHE_LOG2_RST;
        cur_block_log2 = BLOCK_LOG2_RST;
        reload_cache_state();

        // reset geometry: 1024 words, 64-word cache, 4-word blocks
        row_known(FN_READ,  10'd0,    32'd0,        ST_MISS, 0, 0,  0,  32'd1024);
        row_known(FN_READ,  10'd0,    32'd0,        ST_HIT,  0, 0,  0,  32'd1024);
        row_known(FN_WRITE, 10'd1023, 32'h7fffffff, ST_MISS, 3, 15, 15, 32'h7fffffff);
        row_known(FN_READ,  10'd1023, 32'd0,        ST_HIT,  3, 15, 15, 32'h7fffffff);
        row_known(FN_WRITE, 10'd1023, 32'h80000000, ST_HIT,  3, 15, 15, 32'h80000000);
        row_known(FN_WRITE, 10'd3,    32'hffffffff, ST_HIT,  3, 0,  0,  32'hffffffff);
        // conflict on line 0 evicts tag 0
        row_known(FN_READ,  10'd64,   32'd0,        ST_MISS, 0, 0,  1,  32'd960);
        row_known(FN_READ,  10'd0,    32'd0,        ST_MISS, 0, 0,  0,  32'd1024);
        // 32-word memory: out of range above it
        row_cfg(CFG_MEM_LOG2, 4'd5);
        row_known(FN_READ,  10'd32,   32'd0,        ST_RANGE, 0, 0, 0, 32'd0);
        row_known(FN_WRITE, 10'd1023, 32'h0000ffff, ST_RANGE, 0, 0, 0, 32'd0);
        row_known(FN_WRITE, 10'd31,   32'h12345678, ST_MISS,  3, 7, 0, 32'h12345678);
        // block bigger than cache, checked before the address
        row_cfg(CFG_BLOCK_LOG2, 4'd7);
        row_known(FN_WRITE, 10'd5,    32'haaaaaaaa, ST_EXCEED, 0, 0, 0, 32'd0);
        row_known(FN_READ,  10'd1023, 32'd0,        ST_EXCEED, 0, 0, 0, 32'd0);
        // one-word cache, one-word block: single line, tag is the address
        row_cfg(CFG_BLOCK_LOG2, 4'd0);
        row_cfg(CFG_CACHE_LOG2, 4'd0);
        row_known(FN_READ,  10'd0,    32'd0,        ST_MISS, 0, 0, 0, 32'd32);
        row_known(FN_READ,  10'd1,    32'd0,        ST_MISS, 0, 0, 1, 32'd31);
        row_known(FN_READ,  10'd1,    32'd0,        ST_HIT,  0, 0, 1, 32'd31);
        // oversized values clip to the address width
        row_cfg(CFG_MEM_LOG2,   4'd15);
        row_cfg(CFG_CACHE_LOG2, 4'd15);
        row_cfg(CFG_BLOCK_LOG2, 4'd15);
        row_known(FN_READ,  10'd1023, 32'd0,        ST_MISS, 1023, 0, 0, 32'd1);
        row_known(FN_READ,  10'd0,    32'd0,        ST_HIT,  0,    0, 0, 32'd1024);
        // spare index leaves state alone
        row_cfg(CFG_SPARE, 4'd9);
        row_known(FN_READ,  10'd1023, 32'd0,        ST_HIT,  1023, 0, 0, 32'd1);
        // 1024 one-word lines
        row_cfg(CFG_BLOCK_LOG2, 4'd0);
        row_known(FN_WRITE, 10'd512,  32'h5a5aa5a5, ST_MISS, 0, 512, 0, 32'h5a5aa5a5);
        row_access(FN_READ,  10'd512, 32'd0);
        row_access(FN_WRITE, 10'd0,   32'd0);
        row_access(FN_READ,  10'd0,   32'hffffffff);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                write_register(directed_rows[k].idx, directed_rows[k].val);
            end else begin
                send_access(directed_rows[k].func, directed_rows[k].addr,
                            directed_rows[k].wval, directed_rows[k].typed,
                            directed_rows[k].want);
            end
        end

        // random phases: new geometry each, sender gaps 11%, then 66%, then none
        for (int p = 0; p < NUM_PHASES; p++) begin
            gap_pct = (p < 4) ? 11 : (p < 7) ? 66 : 0;
            write_register(CFG_MEM_LOG2,   CFG_W'(PHASE_SET[p][0]));
            write_register(CFG_CACHE_LOG2, CFG_W'(PHASE_SET[p][1]));
            write_register(CFG_BLOCK_LOG2, CFG_W'(PHASE_SET[p][2]));
            msize = 1 << clip_log2(cur_mem_log2);
            csize = 1 << clip_log2(cur_cache_log2);
            bsize = 1 << clip_log2(cur_block_log2);
            recent.delete();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 50 && recent.size() > 0) begin
                    // reuse a recent block, any word in it
                    addr = recent[$urandom_range(recent.size() - 1)]
                           ^ AW'($urandom_range(bsize - 1));
                end else if (pick < 70 && recent.size() > 0) begin
                    // same line, other tag: forces evictions
                    addr = AW'((int'(recent[$urandom_range(recent.size() - 1)])
                               + csize * $urandom_range(1, 3)) % msize);
                end else if (pick < 90) begin
                    addr = AW'($urandom_range(msize - 1));
                end else begin
                    // anywhere, mostly out of range for small memories
                    addr = AW'($urandom);
                end
                recent.push_back(addr);
                if (recent.size() > 8) void'(recent.pop_front());
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(3))
                        0: wval = '0;
                        1: wval = '1;
                        2: wval = 32'h7fffffff;
                        default: wval = 32'h80000000;
                    endcase
                end else begin
                    wval = $urandom;
                end
                send_access(bit'($urandom_range(1)), addr, wval, 1'b0, '0);
            end
        end

        // drain, bounded, then let the pipeline settle
        start <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (4) @(posedge i_clk);
        leftover = pending_results.size();
        if (leftover != 0) begin
            $display("%0d expected results never arrived", leftover);
        end

        $display("%0d items, %0d results, %0d register writes, %0d mismatches",
                 items_sent, results_seen, cfg_writes, mismatches);
        $display("hits %0d, misses %0d, out of range %0d, block over cache %0d",
                 status_count[ST_HIT], status_count[ST_MISS],
                 status_count[ST_RANGE], status_count[ST_EXCEED]);
        if (mismatches == 0 && leftover == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("run timed out");
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hdl/dmc_pkg.sv
hdl/dmc_ram.sv
hdl/dmc_init.sv
hdl/direct_mapped_cache_sim_core.sv
hdl/dmc_checker.sv
tb/sv/tb_direct_mapped_cache_sim_core.sv
